### rtl/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types, radix constants and digit carry/borrow helpers for the
// hours:minutes:seconds.milliseconds accumulator.
// ----------------------------------------------------------------------------
package hms_pkg;

    localparam int unsigned HOURS_W   = 8;
    localparam int unsigned MINUTES_W = 6;
    localparam int unsigned SECONDS_W = 6;
    localparam int unsigned MILLIS_W  = 10;
    localparam int unsigned TIME_W    = HOURS_W + MINUTES_W + SECONDS_W + MILLIS_W;
    localparam int unsigned TDATA_W   = ((TIME_W + 7) / 8) * 8;

    // Working width of one digit step: wide enough for 999 + 1023 + 2.
    localparam int unsigned DIGIT_W   = 12;

    localparam logic [DIGIT_W-1:0] MS_RADIX = 12'd1000;
    localparam logic [DIGIT_W-1:0] SM_RADIX = 12'd60;

    localparam logic [MINUTES_W-1:0] SM_MAX = 6'd59;
    localparam logic [MILLIS_W-1:0]  MS_MAX = 10'd999;

    // Request kinds carried in tuser.
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_SUB = 1'b1;

    // The first member sits in the highest bits, so hours land in bits 7:0.
    typedef struct packed {
        logic [MILLIS_W-1:0]  millis;
        logic [SECONDS_W-1:0] seconds;
        logic [MINUTES_W-1:0] minutes;
        logic [HOURS_W-1:0]   hours;
    } t_time;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [1:0]         carry;
    } t_digit;

    // cur + d + cin, reduced by at most two radix units.
    function automatic t_digit add_digit(input logic [DIGIT_W-1:0] cur,
                                         input logic [DIGIT_W-1:0] d,
                                         input logic [1:0]         cin,
                                         input logic [DIGIT_W-1:0] radix);
        logic [DIGIT_W-1:0] s;
        logic [DIGIT_W:0]   two_r;
        t_digit             r;
        s     = cur + d + DIGIT_W'(cin);
        two_r = {radix, 1'b0};
        if ({1'b0, s} >= two_r) begin
            r.digit = s - two_r[DIGIT_W-1:0];
            r.carry = 2'd2;
        end else if (s >= radix) begin
            r.digit = s - radix;
            r.carry = 2'd1;
        end else begin
            r.digit = s;
            r.carry = 2'd0;
        end
        return r;
    endfunction

    // cur - d - bin, lifted by at most two radix units.
    function automatic t_digit sub_digit(input logic [DIGIT_W-1:0] cur,
                                         input logic [DIGIT_W-1:0] d,
                                         input logic [1:0]         bin,
                                         input logic [DIGIT_W-1:0] radix);
        logic [DIGIT_W-1:0]        need;
        logic signed [DIGIT_W:0]   diff;
        logic signed [DIGIT_W:0]   diff1;
        logic signed [DIGIT_W:0]   diff2;
        t_digit                    r;
        need  = d + DIGIT_W'(bin);
        diff  = $signed({1'b0, cur}) - $signed({1'b0, need});
        diff1 = diff + $signed({1'b0, radix});
        diff2 = diff1 + $signed({1'b0, radix});
        if (diff >= 0) begin
            r.digit = diff[DIGIT_W-1:0];
            r.carry = 2'd0;
        end else if (diff1 >= 0) begin
            r.digit = diff1[DIGIT_W-1:0];
            r.carry = 2'd1;
        end else begin
            r.digit = diff2[DIGIT_W-1:0];
            r.carry = 2'd2;
        end
        return r;
    endfunction

endpackage

### rtl/hms_ms_time_accumulator.sv
// ----------------------------------------------------------------------------
// hms_ms_time_accumulator
// Stopwatch time kept as hours:minutes:seconds.milliseconds, updated by
// add or subtract requests; every request returns the time after it.
// ----------------------------------------------------------------------------
// The block accepts one item per clock unless the output stalls and returns
// one result item for each, in order. An accepted item sits in the input
// register while the carry and borrow chain (milliseconds at 1000, seconds
// and minutes at 60, hours wrap modulo 256) settles, and the time and result
// registers take it once the result register is empty or draining. Throughput
// is one item per cycle unless the output stalls; the single combinational
// pass through the three digit stages sets the clock limit. A result waiting
// on a stalled output holds the stage behind it, and a new item is still taken
// as long as the input register is free or moving. Digits of the amount above
// their nominal range are honored, carrying or borrowing up to two units into
// the next digit. With run_enable cleared the time is frozen but every item
// still returns it. run_enable resets to 1 and must only be written while no
// items are in flight; the configuration channel is always ready.
// ----------------------------------------------------------------------------
module hms_ms_time_accumulator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: delta_hours[7:0], delta_minutes[13:8], delta_seconds[19:14],
    //        delta_millis[29:20], zero fill [31:30]
    input  logic [hms_pkg::TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type (0 add, 1 subtract)
    input  logic                        s_axis_tuser,

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata: cur_hours[7:0], cur_minutes[13:8], cur_seconds[19:14],
    //        cur_millis[29:20], zero fill [31:30]
    output logic [hms_pkg::TDATA_W-1:0] m_axis_tdata,

    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);

    // Input stage.
    logic           r_in_valid;
    hms_pkg::t_time r_in_delta;
    logic           r_in_sub;

    // Kept time, run control and result stage.
    hms_pkg::t_time r_time;
    logic           r_run_en;
    logic           r_out_valid;
    hms_pkg::t_time r_out_time;

    hms_pkg::t_time w_step;
    hms_pkg::t_time n_time;
    logic           w_adv;

    // The update stage moves whenever the result register is empty or being
    // drained this cycle.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(hms_pkg::TDATA_W - hms_pkg::TIME_W){1'b0}}, r_out_time};

    hms_step u_step (
        .i_cur   (r_time),
        .i_delta (r_in_delta),
        .i_sub   (r_in_sub),
        .o_next  (w_step)
    );

    // A frozen clock still answers with the current time.
    assign n_time = r_run_en ? w_step : r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_run_en    <= 1'b1;
            r_time      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_run_en <= i_cfg_data;
            end

            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end

            if (r_in_valid && w_adv) begin
                r_time      <= n_time;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_delta <= s_axis_tdata[hms_pkg::TIME_W-1:0];
            r_in_sub   <= s_axis_tuser;
        end
        if (r_in_valid && w_adv) begin
            r_out_time <= n_time;
        end
    end

`ifndef ASSERT_OFF
    // The kept time is always normalized.
    a_time_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_time.minutes <= hms_pkg::SM_MAX) && (r_time.seconds <= hms_pkg::SM_MAX)
        && (r_time.millis <= hms_pkg::MS_MAX))
        else $error("kept time holds a digit out of range");

    // A frozen clock leaves the time untouched when it answers an item.
    a_frozen_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv && !r_run_en) |=> $stable(r_time))
        else $error("time changed while run is disabled");

    // Each result reports the time as left by its own item.
    a_result_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv) |=> (r_out_valid && (r_out_time == r_time)))
        else $error("result does not match the kept time");

    // A blocked input stage keeps its item.
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_delta)
        && $stable(r_in_sub)))
        else $error("input item lost while the result stage was stalled");
`endif

endmodule

### rtl/hms_step.sv
// ----------------------------------------------------------------------------
// hms_step
// Combinational add/subtract of one time amount to the kept time, with
// carries and borrows rippling from milliseconds up to the hours.
// ----------------------------------------------------------------------------
module hms_step (
    input  hms_pkg::t_time i_cur,
    input  hms_pkg::t_time i_delta,
    input  logic           i_sub,
    output hms_pkg::t_time o_next
);

    hms_pkg::t_digit w_ms;
    hms_pkg::t_digit w_sec;
    hms_pkg::t_digit w_min;

    always_comb begin
        if (i_sub == hms_pkg::REQ_SUB) begin
            w_ms  = hms_pkg::sub_digit(hms_pkg::DIGIT_W'(i_cur.millis),
                                       hms_pkg::DIGIT_W'(i_delta.millis),
                                       2'd0, hms_pkg::MS_RADIX);
            w_sec = hms_pkg::sub_digit(hms_pkg::DIGIT_W'(i_cur.seconds),
                                       hms_pkg::DIGIT_W'(i_delta.seconds),
                                       w_ms.carry, hms_pkg::SM_RADIX);
            w_min = hms_pkg::sub_digit(hms_pkg::DIGIT_W'(i_cur.minutes),
                                       hms_pkg::DIGIT_W'(i_delta.minutes),
                                       w_sec.carry, hms_pkg::SM_RADIX);
            o_next.hours = i_cur.hours - i_delta.hours
                         - hms_pkg::HOURS_W'(w_min.carry);
        end else begin
            w_ms  = hms_pkg::add_digit(hms_pkg::DIGIT_W'(i_cur.millis),
                                       hms_pkg::DIGIT_W'(i_delta.millis),
                                       2'd0, hms_pkg::MS_RADIX);
            w_sec = hms_pkg::add_digit(hms_pkg::DIGIT_W'(i_cur.seconds),
                                       hms_pkg::DIGIT_W'(i_delta.seconds),
                                       w_ms.carry, hms_pkg::SM_RADIX);
            w_min = hms_pkg::add_digit(hms_pkg::DIGIT_W'(i_cur.minutes),
                                       hms_pkg::DIGIT_W'(i_delta.minutes),
                                       w_sec.carry, hms_pkg::SM_RADIX);
            o_next.hours = i_cur.hours + i_delta.hours
                         + hms_pkg::HOURS_W'(w_min.carry);
        end
        // Digits are below their radix here, so the narrowing is exact.
        o_next.millis  = w_ms.digit[hms_pkg::MILLIS_W-1:0];
        o_next.seconds = w_sec.digit[hms_pkg::SECONDS_W-1:0];
        o_next.minutes = w_min.digit[hms_pkg::MINUTES_W-1:0];
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stopwatch time accumulator. Random add and
// subtract items are streamed in with random gaps and output stalls, and a
// scoreboard predicts the time after every accepted item.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned MILLIS_PER_SEC = 1000;
    localparam int unsigned UNITS_PER_MIN  = 60;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    // The scoreboard carries its own copy of the kept time and of the run
    // register. Each accepted request advances that copy and the resulting
    // time is queued; each accepted result is checked against the oldest
    // queued time.
    class stopwatch_scoreboard;
        hms_pkg::t_time kept_time;
        bit             run_on;
        hms_pkg::t_time expected_times[$];
        int unsigned    errors;

        function new();
            kept_time = '0;
            run_on    = 1'b1;
            errors    = 0;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        function void set_run(input bit value);
            run_on = value;
        endfunction

        function int pending();
            return expected_times.size();
        endfunction

        // One digit of a subtraction: lift the digit by whole radix units
        // until the amount fits, and count those units as the borrow out.
        function int unsigned lower_digit(input int unsigned cur,
                                          input int unsigned need,
                                          input int unsigned radix,
                                          output int unsigned borrow);
            int unsigned lifted;
            lifted = cur;
            borrow = 0;
            while (lifted < need) begin
                lifted += radix;
                borrow++;
            end
            return lifted - need;
        endfunction

        function void advance_time(input logic req, input hms_pkg::t_time delta);
            int unsigned sum;
            int unsigned k;
            if (!run_on) begin
                return;
            end
            if (req == hms_pkg::REQ_ADD) begin
                sum = kept_time.millis + delta.millis;
                kept_time.millis = hms_pkg::MILLIS_W'(sum % MILLIS_PER_SEC);
                k = sum / MILLIS_PER_SEC;
                sum = kept_time.seconds + delta.seconds + k;
                kept_time.seconds = hms_pkg::SECONDS_W'(sum % UNITS_PER_MIN);
                k = sum / UNITS_PER_MIN;
                sum = kept_time.minutes + delta.minutes + k;
                kept_time.minutes = hms_pkg::MINUTES_W'(sum % UNITS_PER_MIN);
                k = sum / UNITS_PER_MIN;
                kept_time.hours = kept_time.hours + delta.hours
                                + hms_pkg::HOURS_W'(k);
            end else begin
                k = 0;
                kept_time.millis = hms_pkg::MILLIS_W'(lower_digit(kept_time.millis,
                    delta.millis + k, MILLIS_PER_SEC, k));
                kept_time.seconds = hms_pkg::SECONDS_W'(lower_digit(kept_time.seconds,
                    delta.seconds + k, UNITS_PER_MIN, k));
                kept_time.minutes = hms_pkg::MINUTES_W'(lower_digit(kept_time.minutes,
                    delta.minutes + k, UNITS_PER_MIN, k));
                kept_time.hours = kept_time.hours - delta.hours
                                - hms_pkg::HOURS_W'(k);
            end
        endfunction

        function void note_request(input logic req, input hms_pkg::t_time delta);
            advance_time(req, delta);
            expected_times.push_back(kept_time);
        endfunction

        task check_time(input logic [hms_pkg::TDATA_W-1:0] data);
            hms_pkg::t_time got;
            hms_pkg::t_time want;
            got = hms_pkg::t_time'(data[hms_pkg::TIME_W-1:0]);
            if (expected_times.size() == 0) begin
                report_mismatch($sformatf("result %h with no expected time", data));
                return;
            end
            want = expected_times.pop_front();
            if (got.hours !== want.hours)
                report_mismatch($sformatf("hours %0d, expected %0d",
                                          got.hours, want.hours));
            if (got.minutes !== want.minutes)
                report_mismatch($sformatf("minutes %0d, expected %0d",
                                          got.minutes, want.minutes));
            if (got.seconds !== want.seconds)
                report_mismatch($sformatf("seconds %0d, expected %0d",
                                          got.seconds, want.seconds));
            if (got.millis !== want.millis)
                report_mismatch($sformatf("millis %0d, expected %0d",
                                          got.millis, want.millis));
            if (data[hms_pkg::TDATA_W-1:hms_pkg::TIME_W] !== '0)
                report_mismatch($sformatf("fill bits of result %h not zero", data));
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    // tdata: delta_hours[7:0], delta_minutes[13:8], delta_seconds[19:14],
    //        delta_millis[29:20], zero fill [31:30]
    logic [hms_pkg::TDATA_W-1:0] s_axis_tdata = '0;
    // tuser: req_type (0 add, 1 subtract)
    logic                        s_axis_tuser = hms_pkg::REQ_ADD;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    // tdata: cur_hours[7:0], cur_minutes[13:8], cur_seconds[19:14],
    //        cur_millis[29:20], zero fill [31:30]
    logic [hms_pkg::TDATA_W-1:0] m_axis_tdata;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic                        i_cfg_data = 1'b0;

    // While calm is set neither side inserts gaps or stalls.
    bit                  calm = 1'b0;
    int unsigned         cycle_count = 0;
    stopwatch_scoreboard time_board = new();

    hms_ms_time_accumulator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 6);
    endfunction

    // The receiver decides its stall for the next edge at every falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= !take_break();
    end

    // Both handshakes are observed at the rising edge, where the inputs are
    // stable since the bench only changes them at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                time_board.set_run(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                time_board.note_request(s_axis_tuser,
                    hms_pkg::t_time'(s_axis_tdata[hms_pkg::TIME_W-1:0]));
            if (m_axis_tvalid && m_axis_tready)
                time_board.check_time(m_axis_tdata);
        end
    end

    // A hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic hms_pkg::t_time make_delta(input int unsigned hours,
                                                  input int unsigned minutes,
                                                  input int unsigned seconds,
                                                  input int unsigned millis);
        hms_pkg::t_time d;
        d.hours   = hms_pkg::HOURS_W'(hours);
        d.minutes = hms_pkg::MINUTES_W'(minutes);
        d.seconds = hms_pkg::SECONDS_W'(seconds);
        d.millis  = hms_pkg::MILLIS_W'(millis);
        return d;
    endfunction

    // Called and returning at a falling edge. Valid stays high after the
    // item is taken so back-to-back items need no extra edge.
    task automatic send_request(input logic req, input hms_pkg::t_time delta);
        while (take_break()) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = hms_pkg::TDATA_W'(delta);
        s_axis_tuser  = req;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops the sender and waits until every queued time has come back.
    task automatic wait_for_drain();
        s_axis_tvalid = 1'b0;
        while (time_board.pending() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Only called with the block drained.
    task automatic write_run_enable(input bit value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Most items are well-formed amounts with small hour counts, so the time
    // keeps crossing zero in both directions; the rest use every bit of each
    // field, including digits beyond their nominal range.
    task automatic send_random_batch(input int count, input bit pause_midway);
        hms_pkg::t_time delta;
        int unsigned    pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                delta = make_delta(($urandom_range(3) == 0) ? $urandom_range(255)
                                                            : $urandom_range(2),
                                   $urandom_range(59), $urandom_range(59),
                                   $urandom_range(999));
            end else if (pick < 85) begin
                delta = hms_pkg::t_time'($urandom());
            end else begin
                delta.hours   = ($urandom_range(1) == 0) ? '0 : '1;
                delta.minutes = ($urandom_range(2) == 0) ? '0 :
                                ($urandom_range(1) == 0) ? 6'd59 : '1;
                delta.seconds = ($urandom_range(2) == 0) ? '0 :
                                ($urandom_range(1) == 0) ? 6'd59 : '1;
                delta.millis  = ($urandom_range(2) == 0) ? '0 :
                                ($urandom_range(1) == 0) ? 10'd999 : '1;
            end
            send_request($urandom_range(1) ? hms_pkg::REQ_SUB : hms_pkg::REQ_ADD,
                         delta);
            if (pause_midway && n == count / 2)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, starting from the reset time of zero with the
        // clock running. Taking one millisecond from zero borrows through
        // every digit and wraps the hours; adding it back carries through.
        send_request(hms_pkg::REQ_SUB, make_delta(0, 0, 0, 1));
        send_request(hms_pkg::REQ_ADD, make_delta(0, 0, 0, 1));
        send_request(hms_pkg::REQ_ADD, make_delta(0, 59, 59, 999));
        send_request(hms_pkg::REQ_ADD, make_delta(0, 0, 0, 1));
        send_request(hms_pkg::REQ_SUB, make_delta(0, 59, 59, 999));
        // Every bit of every field high, digits well past their range.
        send_request(hms_pkg::REQ_ADD, make_delta(255, 63, 63, 1023));
        send_request(hms_pkg::REQ_ADD, make_delta(255, 63, 63, 1023));
        send_request(hms_pkg::REQ_SUB, make_delta(255, 63, 63, 1023));
        send_request(hms_pkg::REQ_SUB, make_delta(255, 63, 63, 1023));
        send_request(hms_pkg::REQ_SUB, make_delta(0, 63, 63, 1023));
        // Hour overflow wraps modulo 256.
        send_request(hms_pkg::REQ_ADD, make_delta(200, 0, 0, 0));
        send_request(hms_pkg::REQ_ADD, make_delta(200, 0, 0, 0));
        send_request(hms_pkg::REQ_ADD, make_delta(0, 0, 0, 0));
        send_request(hms_pkg::REQ_SUB, make_delta(0, 0, 0, 0));
        wait_for_drain();

        // Frozen: the time must come back unchanged whatever is asked.
        write_run_enable(1'b0);
        send_request(hms_pkg::REQ_ADD, make_delta(255, 63, 63, 1023));
        send_request(hms_pkg::REQ_SUB, make_delta(1, 2, 3, 4));
        send_request(hms_pkg::REQ_SUB, make_delta(255, 63, 63, 1023));
        send_request(hms_pkg::REQ_ADD, make_delta(0, 0, 0, 0));
        wait_for_drain();
        write_run_enable(1'b1);

        // Random phases alternating the run register; the first one also
        // lets the block empty out halfway, and one long phase is calm.
        send_random_batch(400, 1'b1);
        write_run_enable(1'b0);
        send_random_batch(200, 1'b0);
        write_run_enable(1'b1);
        calm = 1'b1;
        send_random_batch(400, 1'b0);
        calm = 1'b0;
        write_run_enable(1'b0);
        send_random_batch(100, 1'b0);
        write_run_enable(1'b1);
        send_random_batch(300, 1'b0);

        // Any stray result after the drain would show up here.
        repeat (8) @(posedge i_clk);
        if (time_board.errors == 0 && time_board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

### hms_ms_time_accumulator.f
rtl/hms_pkg.sv
rtl/hms_step.sv
rtl/hms_ms_time_accumulator.sv
tb/sv/tb.sv
